@@ src/shs_pkg.sv @@
package shs_pkg;

  // Driver command words for one single step
  localparam logic [15:0] WORD_UP = 16'hC041;
  localparam logic [15:0] WORD_DN = 16'h8041;

  // Register defaults
  localparam logic [11:0] TIMEOUT_RESET = 12'd1600;

  // Dwell values in half-millisecond units
  localparam logic [3:0] WAIT_NONE       = 4'd0;
  localparam logic [3:0] WAIT_SEEK       = 4'd1;
  localparam logic [3:0] WAIT_SEEK_BACK  = 4'd3;
  localparam logic [3:0] WAIT_OVER_FIRST = 4'd4;
  localparam logic [3:0] WAIT_OVER_LAST  = 4'd6;
  localparam logic [3:0] WAIT_FINAL_UP   = 4'd4;
  localparam logic [3:0] WAIT_FINAL_DN   = 4'd8;
  localparam logic [3:0] WAIT_RAMP_SLOW  = 4'd4;
  localparam logic [3:0] WAIT_RAMP_MID   = 4'd2;
  localparam logic [3:0] WAIT_RAMP_FAST  = 4'd1;

  // Final run lengths
  localparam logic [2:0] FINAL_STEPS_UP = 3'd5;
  localparam logic [2:0] FINAL_STEPS_DN = 3'd3;

  // Register map, index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_AIR_MODE      = 2'd0,
    REG_DIR_INVERT    = 2'd1,
    REG_FINAL_MODE    = 2'd2,
    REG_TIMEOUT_LIMIT = 2'd3
  } shs_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SEEK_DOWN = 3'd1,
    PH_LEAVE_UP  = 3'd2,
    PH_OVERSHOOT = 3'd3,
    PH_SEEK_BACK = 3'd4,
    PH_FINAL     = 3'd5
  } shs_phase_t;

  typedef struct packed {
    logic start_req;
    logic sensor_covered;
    logic external_error;
  } shs_in_t;

  typedef struct packed {
    logic        step_valid;
    logic        step_up;
    logic [15:0] command_word;
    logic [3:0]  wait_before;
    logic [3:0]  wait_after;
    logic        busy_res;
    logic        done_res;
    logic        timed_out;
    logic        aborted;
    logic        air_lift;
  } shs_out_t;

endpackage

@@ src/stepper_homing_sequencer.sv @@
// A result appears in the output register in the cycle after its poll transfer.
// Throughput: one poll per cycle unless a held result is stalled; the phase and counter
// update is a single pass of logic between the accepted poll and the output register.
// Reset (rst_n low, synchronous): phase idle, counters zero, registers at defaults
// (timeout_limit 1600), output register empty.
module stepper_homing_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  shs_pkg::shs_in_t    in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output shs_pkg::shs_out_t   out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Configuration registers
  logic        air_mode_r;
  logic        dir_invert_r;
  logic        final_mode_r;
  logic [11:0] timeout_limit_r;

  // Sequencer state
  shs_pkg::shs_phase_t phase_r, phase_nxt;
  logic [11:0] seek_count_r, seek_count_nxt;
  logic [2:0]  ramp_count_r, ramp_count_nxt;
  logic [2:0]  fixed_count_r, fixed_count_nxt;

  // Output register
  logic              out_valid_r;
  shs_pkg::shs_out_t out_data_r;
  shs_pkg::shs_out_t res_nxt;

  logic              in_xfer;
  logic              cfg_wr;
  shs_pkg::shs_reg_t reg_idx;

  // Per-item step selection
  logic        do_seek;
  logic        do_final;
  logic        do_fixed;
  logic        seek_up;
  logic [3:0]  seek_wa;
  logic [11:0] seek_cur;
  logic [2:0]  fixed_cur;
  logic [2:0]  fixed_total;
  logic        fixed_up;
  logic [3:0]  fixed_wa;
  logic [3:0]  ramp_w;
  logic [2:0]  ramp_inc;

  assign in_stall  = out_valid_r & out_stall;
  assign in_xfer   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // APB register port
  assign pready  = 1'b1;
  assign reg_idx = shs_pkg::shs_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    unique case (reg_idx)
      shs_pkg::REG_AIR_MODE:      prdata = {31'd0, air_mode_r};
      shs_pkg::REG_DIR_INVERT:    prdata = {31'd0, dir_invert_r};
      shs_pkg::REG_FINAL_MODE:    prdata = {31'd0, final_mode_r};
      shs_pkg::REG_TIMEOUT_LIMIT: prdata = {20'd0, timeout_limit_r};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      air_mode_r      <= 1'b0;
      dir_invert_r    <= 1'b0;
      final_mode_r    <= 1'b0;
      timeout_limit_r <= shs_pkg::TIMEOUT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        shs_pkg::REG_AIR_MODE:      air_mode_r      <= pwdata[0];
        shs_pkg::REG_DIR_INVERT:    dir_invert_r    <= pwdata[0];
        shs_pkg::REG_FINAL_MODE:    final_mode_r    <= pwdata[0];
        shs_pkg::REG_TIMEOUT_LIMIT: timeout_limit_r <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Seek dwell ramp: two slow steps, two medium, then fast
  always_comb begin
    if (ramp_count_r < 3'd2) begin
      ramp_w = shs_pkg::WAIT_RAMP_SLOW;
    end else if (ramp_count_r < 3'd4) begin
      ramp_w = shs_pkg::WAIT_RAMP_MID;
    end else begin
      ramp_w = shs_pkg::WAIT_RAMP_FAST;
    end
    ramp_inc = (ramp_count_r < 3'd4) ? ramp_count_r + 3'd1 : ramp_count_r;
  end

  // Phase transition and result for one poll
  always_comb begin
    phase_nxt       = phase_r;
    seek_count_nxt  = seek_count_r;
    ramp_count_nxt  = ramp_count_r;
    fixed_count_nxt = fixed_count_r;
    res_nxt         = '0;
    do_seek         = 1'b0;
    do_final        = 1'b0;
    do_fixed        = 1'b0;
    seek_up         = 1'b0;
    seek_wa         = shs_pkg::WAIT_NONE;
    seek_cur        = seek_count_r;
    fixed_cur       = fixed_count_r;
    fixed_up        = 1'b1;
    fixed_wa        = shs_pkg::WAIT_NONE;
    fixed_total     = final_mode_r ? shs_pkg::FINAL_STEPS_UP : shs_pkg::FINAL_STEPS_DN;

    unique case (phase_r)
      shs_pkg::PH_IDLE: begin
        if (in_data.start_req) begin
          if (air_mode_r) begin
            res_nxt.air_lift = 1'b1;
          end else if (in_data.external_error) begin
            res_nxt.aborted = 1'b1;
          end else begin
            // Start sample doubles as first poll: ramp and count restart
            do_seek        = 1'b1;
            seek_up        = in_data.sensor_covered;
            seek_wa        = shs_pkg::WAIT_RAMP_SLOW;
            seek_cur       = 12'd0;
            seek_count_nxt = 12'd0;
            ramp_count_nxt = 3'd1;
            phase_nxt      = in_data.sensor_covered ? shs_pkg::PH_LEAVE_UP
                                                    : shs_pkg::PH_SEEK_DOWN;
          end
        end
      end
      shs_pkg::PH_SEEK_DOWN: begin
        if (in_data.sensor_covered) begin
          do_final  = 1'b1;
          fixed_cur = 3'd0;
          phase_nxt = shs_pkg::PH_FINAL;
        end else begin
          do_seek        = 1'b1;
          seek_wa        = ramp_w;
          ramp_count_nxt = ramp_inc;
        end
      end
      shs_pkg::PH_LEAVE_UP: begin
        if (in_data.sensor_covered) begin
          do_seek        = 1'b1;
          seek_up        = 1'b1;
          seek_wa        = ramp_w;
          ramp_count_nxt = ramp_inc;
        end else begin
          do_fixed        = 1'b1;
          fixed_wa        = shs_pkg::WAIT_OVER_FIRST;
          fixed_count_nxt = 3'd1;
          phase_nxt       = shs_pkg::PH_OVERSHOOT;
        end
      end
      shs_pkg::PH_OVERSHOOT: begin
        do_fixed        = 1'b1;
        fixed_wa        = shs_pkg::WAIT_OVER_LAST;
        seek_count_nxt  = 12'd0;
        fixed_count_nxt = 3'd0;
        phase_nxt       = shs_pkg::PH_SEEK_BACK;
      end
      shs_pkg::PH_SEEK_BACK: begin
        if (in_data.sensor_covered) begin
          do_final  = 1'b1;
          fixed_cur = 3'd0;
          phase_nxt = shs_pkg::PH_FINAL;
        end else begin
          do_seek = 1'b1;
          seek_wa = shs_pkg::WAIT_SEEK_BACK;
        end
      end
      shs_pkg::PH_FINAL: begin
        do_final = 1'b1;
      end
      default: begin
        phase_nxt = shs_pkg::PH_IDLE;
      end
    endcase

    // Final run step: direction and dwell follow final_mode at each step
    if (do_final) begin
      do_fixed        = 1'b1;
      fixed_up        = final_mode_r;
      fixed_wa        = final_mode_r ? shs_pkg::WAIT_FINAL_UP : shs_pkg::WAIT_FINAL_DN;
      fixed_count_nxt = fixed_cur + 3'd1;
      if (fixed_count_nxt >= fixed_total) begin
        phase_nxt        = shs_pkg::PH_IDLE;
        res_nxt.done_res = 1'b1;
      end
    end

    // Fixed step without dwell before
    if (do_fixed) begin
      res_nxt.step_valid   = 1'b1;
      res_nxt.step_up      = fixed_up;
      res_nxt.command_word = (fixed_up ^ dir_invert_r) ? shs_pkg::WORD_UP
                                                       : shs_pkg::WORD_DN;
      res_nxt.wait_before  = shs_pkg::WAIT_NONE;
      res_nxt.wait_after   = fixed_wa;
    end

    // Seek step: issue, then check error, then timeout
    if (do_seek) begin
      res_nxt.step_valid   = 1'b1;
      res_nxt.step_up      = seek_up;
      res_nxt.command_word = (seek_up ^ dir_invert_r) ? shs_pkg::WORD_UP
                                                      : shs_pkg::WORD_DN;
      res_nxt.wait_before  = shs_pkg::WAIT_SEEK;
      res_nxt.wait_after   = seek_wa;
      if (in_data.external_error) begin
        res_nxt.aborted = 1'b1;
        phase_nxt       = shs_pkg::PH_IDLE;
      end else if (seek_cur >= timeout_limit_r) begin
        res_nxt.timed_out = 1'b1;
        phase_nxt         = shs_pkg::PH_IDLE;
      end else begin
        seek_count_nxt = seek_cur + 12'd1;
      end
    end

    res_nxt.busy_res = (phase_nxt != shs_pkg::PH_IDLE);
  end

  // Advance state on each poll transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= shs_pkg::PH_IDLE;
      seek_count_r  <= 12'd0;
      ramp_count_r  <= 3'd0;
      fixed_count_r <= 3'd0;
    end else if (in_xfer) begin
      phase_r       <= phase_nxt;
      seek_count_r  <= seek_count_nxt;
      ramp_count_r  <= ramp_count_nxt;
      fixed_count_r <= fixed_count_nxt;
    end
  end

  // Output register: load on poll transfer, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

@@ src/shs_checker.sv @@
module shs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input shs_pkg::shs_out_t out_data
);

  // A held result stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Without a step the step fields stay zero
  a_nostep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.step_valid |->
      out_data.command_word == 16'd0 && out_data.wait_before == 4'd0 &&
      out_data.wait_after == 4'd0 && !out_data.step_up)
    else $error("step fields set without a step");

  // A step carries one of the two driver words
  a_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.step_valid |->
      out_data.command_word == shs_pkg::WORD_UP ||
      out_data.command_word == shs_pkg::WORD_DN)
    else $error("bad command word");

  // Ending results leave the sequencer idle
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.done_res || out_data.timed_out ||
                  out_data.aborted || out_data.air_lift) |-> !out_data.busy_res)
    else $error("busy after end of sequence");

  // Done and timeout always come with a step
  a_endstep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.done_res || out_data.timed_out) |-> out_data.step_valid)
    else $error("end of sequence without a step");

endmodule

bind stepper_homing_sequencer shs_checker u_shs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ sim/homing_result_checker.sv @@
module homing_result_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  shs_pkg::shs_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  shs_pkg::shs_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output int                fail_count,
  output int                outstanding
);

  // Shadow copy of the register file
  logic       air_on;
  logic       swap_dir;
  logic       final_up;
  logic [11:0] step_limit;

  // Shadow copy of the sequencer state
  shs_pkg::shs_phase_t phase_now;
  logic [11:0] seek_steps;
  logic [2:0]  ramp_pos;
  logic [2:0]  fixed_steps;

  // Predicted results still owed by the block, oldest first
  shs_pkg::shs_out_t expected_steps[$];

  // Fill in the motor step fields of a result
  function automatic void issue_step(inout shs_pkg::shs_out_t r, input logic up,
                                     input logic [3:0] wb, input logic [3:0] wa);
    r.step_valid   = 1'b1;
    r.step_up      = up;
    r.command_word = (up ^ swap_dir) ? shs_pkg::WORD_UP : shs_pkg::WORD_DN;
    r.wait_before  = wb;
    r.wait_after   = wa;
  endfunction

  // Return the dwell of the next ramped seek step and advance the ramp
  function automatic logic [3:0] ramp_dwell();
    logic [3:0] w;
    w = (ramp_pos < 3'd2) ? 4'd4 : (ramp_pos < 3'd4) ? 4'd2 : 4'd1;
    if (ramp_pos < 3'd4) ramp_pos = ramp_pos + 3'd1;
    return w;
  endfunction

  // Issue one search step, then check the error and the step budget
  function automatic void seek_move(inout shs_pkg::shs_out_t r, input logic up,
                                    input logic [3:0] wa, input logic err);
    issue_step(r, up, 4'd1, wa);
    if (err) begin
      r.aborted = 1'b1;
      phase_now = shs_pkg::PH_IDLE;
    end else if (seek_steps >= step_limit) begin
      r.timed_out = 1'b1;
      phase_now = shs_pkg::PH_IDLE;
    end else begin
      seek_steps = seek_steps + 12'd1;
    end
  endfunction

  // Issue one step of the final run and finish when the run is complete
  function automatic void final_move(inout shs_pkg::shs_out_t r);
    issue_step(r, final_up, 4'd0, final_up ? 4'd4 : 4'd8);
    fixed_steps = fixed_steps + 3'd1;
    if (fixed_steps >= (final_up ? 3'd5 : 3'd3)) begin
      phase_now  = shs_pkg::PH_IDLE;
      r.done_res = 1'b1;
    end
  endfunction

  // Advance the sequencer by one poll and return the result it gives
  function automatic shs_pkg::shs_out_t predict_homing(input shs_pkg::shs_in_t p);
    shs_pkg::shs_out_t r;
    logic [3:0]        w;
    r = '0;
    case (phase_now)
      shs_pkg::PH_IDLE: begin
        if (p.start_req) begin
          if (air_on) begin
            r.air_lift = 1'b1;
          end else if (p.external_error) begin
            r.aborted = 1'b1;
          end else begin
            seek_steps = '0;
            ramp_pos   = '0;
            w = ramp_dwell();
            if (!p.sensor_covered) begin
              phase_now = shs_pkg::PH_SEEK_DOWN;
              seek_move(r, 1'b0, w, 1'b0);
            end else begin
              phase_now = shs_pkg::PH_LEAVE_UP;
              seek_move(r, 1'b1, w, 1'b0);
            end
          end
        end
      end
      shs_pkg::PH_SEEK_DOWN: begin
        if (p.sensor_covered) begin
          phase_now   = shs_pkg::PH_FINAL;
          fixed_steps = '0;
          final_move(r);
        end else begin
          w = ramp_dwell();
          seek_move(r, 1'b0, w, p.external_error);
        end
      end
      shs_pkg::PH_LEAVE_UP: begin
        if (p.sensor_covered) begin
          w = ramp_dwell();
          seek_move(r, 1'b1, w, p.external_error);
        end else begin
          phase_now   = shs_pkg::PH_OVERSHOOT;
          fixed_steps = 3'd1;
          issue_step(r, 1'b1, 4'd0, 4'd4);
        end
      end
      shs_pkg::PH_OVERSHOOT: begin
        issue_step(r, 1'b1, 4'd0, 4'd6);
        phase_now   = shs_pkg::PH_SEEK_BACK;
        seek_steps  = '0;
        fixed_steps = '0;
      end
      shs_pkg::PH_SEEK_BACK: begin
        if (p.sensor_covered) begin
          phase_now   = shs_pkg::PH_FINAL;
          fixed_steps = '0;
          final_move(r);
        end else begin
          seek_move(r, 1'b0, 4'd3, p.external_error);
        end
      end
      shs_pkg::PH_FINAL: final_move(r);
      default: phase_now = shs_pkg::PH_IDLE;
    endcase
    r.busy_res = (phase_now != shs_pkg::PH_IDLE);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Compare each result transfer, queue a prediction for each poll transfer
  always @(posedge clk) begin : monitor
    shs_pkg::shs_out_t want;
    if (!rst_n) begin
      air_on      = 1'b0;
      swap_dir    = 1'b0;
      final_up    = 1'b0;
      step_limit  = 12'd1600;
      phase_now   = shs_pkg::PH_IDLE;
      seek_steps  = '0;
      ramp_pos    = '0;
      fixed_steps = '0;
      fail_count  = 0;
      expected_steps.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_steps.size() == 0) begin
          $error("result transfer with no step command expected");
          fail_count++;
        end else begin
          want = expected_steps.pop_front();
          check_field("step_valid", 16'(want.step_valid), 16'(out_data.step_valid));
          check_field("step_up", 16'(want.step_up), 16'(out_data.step_up));
          check_field("command_word", want.command_word, out_data.command_word);
          check_field("wait_before", 16'(want.wait_before), 16'(out_data.wait_before));
          check_field("wait_after", 16'(want.wait_after), 16'(out_data.wait_after));
          check_field("busy_res", 16'(want.busy_res), 16'(out_data.busy_res));
          check_field("done_res", 16'(want.done_res), 16'(out_data.done_res));
          check_field("timed_out", 16'(want.timed_out), 16'(out_data.timed_out));
          check_field("aborted", 16'(want.aborted), 16'(out_data.aborted));
          check_field("air_lift", 16'(want.air_lift), 16'(out_data.air_lift));
        end
      end
      if (in_valid && !in_stall) expected_steps.push_back(predict_homing(in_data));
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          shs_pkg::REG_AIR_MODE:      air_on     = pwdata[0];
          shs_pkg::REG_DIR_INVERT:    swap_dir   = pwdata[0];
          shs_pkg::REG_FINAL_MODE:    final_up   = pwdata[0];
          shs_pkg::REG_TIMEOUT_LIMIT: step_limit = pwdata[11:0];
          default: ;
        endcase
      end
    end
    outstanding <= expected_steps.size();
  end

endmodule

@@ sim/tb_stepper_homing_sequencer.sv @@
module tb_stepper_homing_sequencer;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD   = 300;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  shs_pkg::shs_in_t  in_data   = '0;
  logic              out_stall = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [3:0]        paddr     = '0;
  logic [31:0]       pwdata    = '0;

  logic              in_stall;
  logic              out_valid;
  shs_pkg::shs_out_t out_data;
  logic [31:0]       prdata;
  logic              pready;

  int          fail_count;
  int          outstanding;
  int          polls_sent = 0;
  int          cycles     = 0;
  logic [11:0] cur_limit  = 12'd1600;
  bit          calm       = 1'b0;
  bit          hold_req   = 1'b0;

  stepper_homing_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  homing_result_checker result_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic rare(input int odds);
    return ($urandom_range(1, odds) == 1);
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Seek lengths: short mostly, around the step budget when that is small
  function automatic int seek_len();
    if (cur_limit <= 12'd40 && $urandom_range(0, 3) == 0)
      return $urandom_range(0, int'(cur_limit) + 2);
    return $urandom_range(0, 6);
  endfunction

  // Drain results, stalling at random; hold off for a long stretch on request
  initial begin : result_drain
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (calm || coin()) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (idle_len() + 1) @(posedge clk);
      end
    end
  end

  // Offer one poll, hold it until the transfer, then idle at random
  task automatic send_poll(input logic s, input logic c, input logic e);
    shs_pkg::shs_in_t p;
    int               gap;
    p.start_req      = s;
    p.sensor_covered = c;
    p.external_error = e;
    in_data  <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    polls_sent++;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input shs_pkg::shs_reg_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One homing attempt with a plausible sensor profile and rare errors
  task automatic home_run();
    logic from_above;
    from_above = coin();
    send_poll(1'b1, from_above, rare(20));
    if (from_above) begin
      repeat (seek_len()) send_poll(coin(), 1'b1, rare(40));
      send_poll(coin(), 1'b0, coin());
      repeat (2) send_poll(coin(), coin(), coin());
    end
    repeat (seek_len()) send_poll(coin(), 1'b0, rare(40));
    send_poll(coin(), 1'b1, coin());
    repeat (5) send_poll(1'b0, coin(), coin());
  endtask

  // Program one register setting, then run random homing traffic under it
  task automatic run_setting(input logic air, input logic inv, input logic fin,
                             input logic [11:0] lim, input int polls);
    int stop_at;
    write_reg(shs_pkg::REG_AIR_MODE, 32'(air));
    write_reg(shs_pkg::REG_DIR_INVERT, 32'(inv));
    write_reg(shs_pkg::REG_FINAL_MODE, 32'(fin));
    write_reg(shs_pkg::REG_TIMEOUT_LIMIT, 32'(lim));
    cur_limit = lim;
    stop_at = polls_sent + polls;
    while (polls_sent < stop_at) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) send_poll(coin(), coin(), coin());
      else home_run();
    end
    settle();
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed polls at reset register values
    send_poll(1'b0, 1'b0, 1'b0);  // idle, nothing happens
    send_poll(1'b0, 1'b1, 1'b1);  // idle, error without start
    send_poll(1'b1, 1'b0, 1'b1);  // start with error aborts at once
    send_poll(1'b1, 1'b0, 1'b0);  // start from below, first seek step
    send_poll(1'b1, 1'b0, 1'b0);  // start while busy is ignored
    send_poll(1'b0, 1'b0, 1'b0);
    send_poll(1'b0, 1'b1, 1'b1);  // covered ends the seek, first final step
    send_poll(1'b1, 1'b1, 1'b1);  // final steps ignore inputs
    send_poll(1'b0, 1'b0, 1'b0);  // last final step, done
    send_poll(1'b1, 1'b1, 1'b0);  // start from above, leave up
    send_poll(1'b0, 1'b1, 1'b0);
    send_poll(1'b0, 1'b0, 1'b1);  // uncovered, first overshoot step
    send_poll(1'b1, 1'b1, 1'b1);  // second overshoot step
    send_poll(1'b0, 1'b0, 1'b0);  // seek back
    send_poll(1'b0, 1'b0, 1'b1);  // error during seek back
    send_poll(1'b1, 1'b1, 1'b0);
    send_poll(1'b0, 1'b1, 1'b1);  // error while leaving up
    send_poll(1'b1, 1'b0, 1'b0);
    repeat (5) send_poll(1'b0, 1'b0, 1'b0);  // ramp runs down to its fastest dwell
    send_poll(1'b0, 1'b0, 1'b1);  // error during seek down
    settle();

    // Random traffic across register settings, extremes included
    run_setting(1'b0, 1'b1, 1'b1, 12'd1, 370);
    hold_req = 1'b1;
    run_setting(1'b0, 1'b0, 1'b0, 12'd4095, 370);
    run_setting(1'b1, 1'b1, 1'b0, 12'd7, 60);
    run_setting(1'b0, 1'b1, 1'b0, 12'd0, 370);
    run_setting(1'b0, 1'b0, 1'b1, 12'd20, 370);
    run_setting(1'b0, 1'b1, 1'b1, 12'd3, 370);

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
src/shs_pkg.sv
src/stepper_homing_sequencer.sv
src/shs_checker.sv
sim/homing_result_checker.sv
sim/tb_stepper_homing_sequencer.sv
